// ----- design/ffstg_pkg.sv -----
package ffstg_pkg;

	// Number of stepper channels; the pin fields are always eight bits wide.
	localparam int CHANNELS = 8;
	localparam int PIN_W = 8;
	localparam int CHAN_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(CHANNELS + 1);

	localparam logic [7:0] RESET_BYTE = 8'd100;
	localparam logic [7:0] DEBUG_FWD_BYTE = 8'd118;
	localparam logic [7:0] DEBUG_BACK_BYTE = 8'd122;
	localparam logic [7:0] TRAVEL_RESET = 8'd120;

	localparam logic ITEM_TICK = 1'b0;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_TICK,
		OP_CLEAR,
		OP_SET
	} op_t;

	// Everything the memory keeps for one channel.
	typedef struct packed {
		logic [15:0] period;
		logic [15:0] tick_count;
		logic [7:0]  head_position;
		logic        moving_backward;
		logic        step_level;
		logic        next_step_level;
	} chan_state_t;

	// What the per-channel update needs to know about the current request.
	typedef struct packed {
		op_t              op;
		logic [CHAN_W-1:0] set_channel;
		logic [15:0]      set_period;
		logic [7:0]       max_travel;
	} alu_ctrl_t;

endpackage

// ----- design/floppy_stepper_tone_generator.sv -----
// Channel   Handshake                 Payload
// in        in_valid / in_stall       operation, byte_value
// out       out_valid / out_stall     step_pins, direction_pins, drive_select_n, home_request
// cfg       cfg_valid / cfg_ready     cfg_data (max_travel)
//
// Each request passes the idle state that takes it, then a walk in which the sequencer reads
// the channel memory one entry per cycle through its single read port and writes each entry
// back, updated, through one write-back port, and then a done state that loads the result.
// After reset the channel memory reads as zero through per-entry written bits; no clearing pass.
// The next request is taken once the previous result has been loaded into the output register,
// which happens as soon as that register is empty or its result is being taken.
module floppy_stepper_tone_generator
	import ffstg_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             operation,
	input  logic [7:0]       byte_value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PIN_W-1:0] step_pins,
	output logic [PIN_W-1:0] direction_pins,
	output logic [PIN_W-1:0] drive_select_n,
	output logic             home_request,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [7:0]       cfg_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DONE
	} state_t;

	// Position within a three-byte command frame.
	typedef enum logic [1:0] {
		PH_CMD = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW = 2'd2
	} phase_t;

	state_t state_q;
	phase_t phase_q;
	phase_t phase_d;
	logic [7:0] pending_channel_q;
	logic [7:0] pending_channel_d;
	logic [7:0] pending_high_q;
	logic [7:0] pending_high_d;
	op_t op_d;
	logic home_d;

	op_t op_q;
	logic home_q;
	logic [CHAN_W-1:0] set_channel_q;
	logic [15:0] set_period_q;
	logic [7:0] max_travel_q;
	logic [CNT_W-1:0] walk_cnt_q;

	logic rd_en;
	logic [CHAN_W-1:0] rd_addr;
	logic rd_vld_s1;
	logic [CHAN_W-1:0] addr_s1;
	chan_state_t rd_data;
	chan_state_t wr_data;
	alu_ctrl_t alu_ctrl;

	// Per-channel status bits mirrored out of the memory so that a result can show all
	// channels at once.
	logic [CHANNELS-1:0] step_q;
	logic [CHANNELS-1:0] backward_q;
	logic [CHANNELS-1:0] active_q;
	logic [PIN_W-1:0] step_vec;
	logic [PIN_W-1:0] dir_vec;
	logic [PIN_W-1:0] sel_vec;

	logic in_accept;
	logic out_free;

	assign in_stall = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign cfg_ready = 1'b1;

	// The single configuration register. The user must write it only while idle; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_travel_q <= TRAVEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_travel_q <= cfg_data;
		end
	end

	// Frame decoder: works out what the accepted request does to the channels and how the
	// parser moves on. Bytes in the high and low positions are always data.
	always_comb begin
		phase_d = phase_q;
		pending_channel_d = pending_channel_q;
		pending_high_d = pending_high_q;
		op_d = OP_NONE;
		home_d = 1'b0;
		if (operation == ITEM_TICK) begin
			op_d = OP_TICK;
		end else begin
			case (phase_q)
				PH_HIGH: begin
					pending_high_d = byte_value;
					phase_d = PH_LOW;
				end
				PH_LOW: begin
					phase_d = PH_CMD;
					// A frame for a channel that does not exist is consumed and dropped.
					if (pending_channel_q < 8'(CHANNELS)) begin
						op_d = OP_SET;
					end
				end
				default: begin
					phase_d = PH_CMD;
					if (byte_value == RESET_BYTE) begin
						op_d = OP_CLEAR;
						home_d = 1'b1;
					end else if (byte_value == DEBUG_FWD_BYTE
						|| byte_value == DEBUG_BACK_BYTE) begin
						phase_d = PH_CMD;
					end else begin
						// Channel number is half the byte less one, wrapping at eight bits.
						pending_channel_d = {1'b0, byte_value[7:1]} - 8'd1;
						phase_d = PH_HIGH;
					end
				end
			endcase
		end
	end

	// The sequencer reads one channel per cycle and writes it back, updated, in the next.
	// A read and a write never hit the same entry in one cycle, so no forwarding is needed.
	assign rd_en = (state_q == S_WALK) && (walk_cnt_q != CNT_W'(CHANNELS));
	assign rd_addr = walk_cnt_q[CHAN_W-1:0];

	assign alu_ctrl.op = op_q;
	assign alu_ctrl.set_channel = set_channel_q;
	assign alu_ctrl.set_period = set_period_q;
	assign alu_ctrl.max_travel = max_travel_q;

	ffstg_chan_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (rd_vld_s1),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	ffstg_chan_alu u_alu (
		.ctrl    (alu_ctrl),
		.channel (addr_s1),
		.cur     (rd_data),
		.nxt     (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			addr_s1 <= '0;
			step_q <= '0;
			backward_q <= '0;
			active_q <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			addr_s1 <= rd_addr;
			if (rd_vld_s1) begin
				step_q[addr_s1] <= wr_data.step_level;
				backward_q[addr_s1] <= wr_data.moving_backward;
				active_q[addr_s1] <= (wr_data.period != 16'd0);
			end
		end
	end

	// Pins of channels that are not built read as stopped and deselected.
	for (genvar i = 0; i < PIN_W; i++) begin : g_pins
		if (i < CHANNELS) begin : g_used
			assign step_vec[i] = step_q[i];
			assign dir_vec[i] = backward_q[i];
			assign sel_vec[i] = ~active_q[i];
		end else begin : g_unused
			assign step_vec[i] = 1'b0;
			assign dir_vec[i] = 1'b0;
			assign sel_vec[i] = 1'b1;
		end
	end

	// Request sequencer, frame parser state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_CMD;
			pending_channel_q <= 8'd0;
			pending_high_q <= 8'd0;
			op_q <= OP_NONE;
			home_q <= 1'b0;
			set_channel_q <= '0;
			set_period_q <= 16'd0;
			walk_cnt_q <= '0;
			out_valid <= 1'b0;
			step_pins <= '0;
			direction_pins <= '0;
			drive_select_n <= '1;
			home_request <= 1'b0;
		end else begin
			// A finished walk loads the output register; otherwise a taken result empties it.
			if (state_q == S_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						phase_q <= phase_d;
						pending_channel_q <= pending_channel_d;
						pending_high_q <= pending_high_d;
						op_q <= op_d;
						home_q <= home_d;
						set_channel_q <= pending_channel_q[CHAN_W-1:0];
						set_period_q <= {pending_high_q, byte_value};
						walk_cnt_q <= '0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (rd_en) begin
						walk_cnt_q <= walk_cnt_q + CNT_W'(1);
					end else begin
						// The last entry is written back in this cycle.
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						step_pins <= step_vec;
						direction_pins <= dir_vec;
						drive_select_n <= sel_vec;
						home_request <= home_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A new result is only ever loaded at the end of a channel walk.
	a_result_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result appeared without a finished channel walk");

	// The write-back never targets the entry being read in the same cycle.
	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && rd_vld_s1 |-> rd_addr != addr_s1)
		else $error("read and write-back collide on one channel entry");

	// The reset command leaves every channel switched off.
	a_home_deselects: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && home_request |-> drive_select_n == '1)
		else $error("home request shown with a channel still selected");

	// An accepted request always starts a walk in the next cycle.
	a_accept_walks: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == S_WALK && walk_cnt_q == '0)
		else $error("accepted request did not start a channel walk");

endmodule

// ----- design/ffstg_chan_mem.sv -----
module ffstg_chan_mem
	import ffstg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [CHAN_W-1:0] rd_addr,
	output chan_state_t       rd_data,
	input  logic              wr_en,
	input  logic [CHAN_W-1:0] wr_addr,
	input  chan_state_t       wr_data
);

	chan_state_t mem [CHANNELS];
	chan_state_t rd_data_q;
	logic [CHANNELS-1:0] written_q;
	logic rd_written_q;

	// An entry that was never written since reset reads as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_written_q ? rd_data_q : '0;

endmodule

// ----- design/ffstg_chan_alu.sv -----
module ffstg_chan_alu
	import ffstg_pkg::*;
(
	input  alu_ctrl_t         ctrl,
	input  logic [CHAN_W-1:0] channel,
	input  chan_state_t       cur,
	output chan_state_t       nxt
);

	logic [15:0] count_inc;
	logic backward;

	always_comb begin
		nxt = cur;
		count_inc = cur.tick_count + 16'd1;
		backward = cur.moving_backward;
		case (ctrl.op)
			OP_TICK: begin
				if (cur.period != 16'd0) begin
					if (count_inc >= cur.period) begin
						// Turn around at the far end first, then at zero.
						if (cur.head_position >= ctrl.max_travel) begin
							backward = 1'b1;
						end else if (cur.head_position == 8'd0) begin
							backward = 1'b0;
						end
						nxt.moving_backward = backward;
						nxt.head_position = backward ? cur.head_position - 8'd1
							: cur.head_position + 8'd1;
						nxt.step_level = cur.next_step_level;
						nxt.next_step_level = ~cur.next_step_level;
						nxt.tick_count = 16'd0;
					end else begin
						nxt.tick_count = count_inc;
					end
				end
			end
			OP_CLEAR: begin
				nxt.period = 16'd0;
				nxt.head_position = 8'd0;
				nxt.moving_backward = 1'b0;
				nxt.step_level = 1'b0;
			end
			OP_SET: begin
				if (channel == ctrl.set_channel) begin
					nxt.period = ctrl.set_period;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
